// ===== src/wrts_pkg.sv =====
// ----------------------------------------------------------------------------
// wrts_pkg
// Shared request/result types and codes of the weighted-ratio task scheduler.
// ----------------------------------------------------------------------------
package wrts_pkg;

  localparam logic       REQ_LOAD     = 1'b0;
  localparam logic       REQ_ADVANCE  = 1'b1;

  localparam logic [1:0] KIND_RANGE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  localparam logic [31:0] TIME_MAX    = 32'hFFFF_FFFF;
  localparam logic [15:0] CAP_RESET   = 16'hFFFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] arrival_tick;
    logic [15:0] priority_req;
    logic [15:0] exec_time;
    logic [15:0] resources;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  task_index;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] now_time;
    logic        all_done;
    logic        last;
  } rsp_t;

endpackage

// ===== src/wrts_fifo.sv =====
// ----------------------------------------------------------------------------
// wrts_fifo
// Small register FIFO used for the request queue and the result queue.
// ----------------------------------------------------------------------------
module wrts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      data[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/wrts_core.sv =====
// ----------------------------------------------------------------------------
// wrts_core
// Back end: holds the task table and walks it entry by entry to find the next
// event, credit, admit, rank and pack tasks, and report closed ranges.
// ----------------------------------------------------------------------------
module wrts_core
  import wrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] capacity,
  input  req_t        in_item,
  input  logic        in_empty,
  output logic        in_pop,
  output rsp_t        out_item,
  output logic        out_push,
  input  logic        out_full
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    IDLE, EVT, CREDIT, ADMIT, PACK, EMIT, FIN
  } state_t;

  state_t state;

  logic [31:0] task_arrival     [MAX_TASKS];
  logic [15:0] task_weight      [MAX_TASKS];
  logic [15:0] task_length      [MAX_TASKS];
  logic [15:0] task_need        [MAX_TASKS];
  logic [15:0] ticks_served     [MAX_TASKS];
  logic [31:0] open_range_start [MAX_TASKS];

  logic [MAX_TASKS-1:0] running_flags;
  logic [MAX_TASKS-1:0] admitted_flags;
  logic [MAX_TASKS-1:0] taken;
  logic [MAX_TASKS-1:0] run;
  logic [CW-1:0]        loaded_count;
  logic [CW-1:0]        admit_pointer;
  logic [31:0]          current_time;
  logic                 started;

  logic [CW-1:0] i;
  logic [32:0]   best;
  logic          have;
  logic [31:0]   evt_time;
  logic          found;
  logic [IW-1:0] pick;
  logic [15:0]   pick_weight;
  logic [15:0]   pick_length;
  logic [15:0]   pick_need;
  logic [15:0]   used;
  logic [1:0]    fin_kind;
  logic          fin_done;

  logic [IW-1:0] ii;
  logic [IW-1:0] ap;
  logic [32:0]   finish;
  logic [31:0]   delta;
  logic [15:0]   rem;
  logic [31:0]   prod_a;
  logic [31:0]   prod_b;
  logic [16:0]   used_sum;
  logic          eligible;
  logic          closes;
  logic          load_bad;

  assign ii       = i[IW-1:0];
  assign ap       = admit_pointer[IW-1:0];
  assign finish   = {1'b0, current_time} + {17'b0, task_length[ii]}
                    - {17'b0, ticks_served[ii]};
  assign delta    = evt_time - current_time;
  assign rem      = task_length[ii] - ticks_served[ii];
  assign prod_a   = {16'b0, task_weight[ii]} * {16'b0, pick_length};
  assign prod_b   = {16'b0, task_length[ii]} * {16'b0, pick_weight};
  assign used_sum = {1'b0, used} + {1'b0, pick_need};
  assign eligible = admitted_flags[ii] && !taken[ii] && (ticks_served[ii] < task_length[ii]);
  assign closes   = running_flags[ii] && !run[ii];
  assign load_bad = started || (loaded_count >= CW'(MAX_TASKS)) || (in_item.exec_time == '0);

  always_comb begin
    in_pop   = (state == IDLE) && !in_empty;
    out_push = 1'b0;
    out_item = '0;
    out_item.now_time = current_time;
    if (state == EMIT && i != loaded_count && closes) begin
      out_push             = 1'b1;
      out_item.kind        = KIND_RANGE;
      out_item.task_index  = 6'(ii);
      out_item.range_start = open_range_start[ii];
      out_item.range_end   = current_time;
    end else if (state == FIN) begin
      out_push          = 1'b1;
      out_item.kind     = fin_kind;
      out_item.all_done = fin_done;
      out_item.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      running_flags  <= '0;
      admitted_flags <= '0;
      loaded_count   <= '0;
      admit_pointer  <= '0;
      current_time   <= '0;
      started        <= 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        ticks_served[k] <= '0;
      end
    end else begin
      unique case (state)
        IDLE: begin
          if (!in_empty) begin
            if (in_item.req_type == REQ_LOAD) begin
              if (load_bad) begin
                fin_kind <= KIND_REJECT;
                fin_done <= 1'b0;
                state    <= FIN;
              end else begin
                task_arrival[loaded_count[IW-1:0]] <= in_item.arrival_tick;
                task_weight[loaded_count[IW-1:0]]  <= in_item.priority_req;
                task_length[loaded_count[IW-1:0]]  <= in_item.exec_time;
                task_need[loaded_count[IW-1:0]]    <= in_item.resources;
                ticks_served[loaded_count[IW-1:0]] <= '0;
                loaded_count                       <= loaded_count + 1'b1;
              end
            end else begin
              started <= 1'b1;
              have    <= admit_pointer < loaded_count;
              best    <= {1'b0, task_arrival[ap]};
              i       <= '0;
              state   <= EVT;
            end
          end
        end
        EVT: begin
          if (i == loaded_count) begin
            i <= '0;
            if (!have) begin
              fin_kind <= KIND_ADVANCE;
              fin_done <= 1'b1;
              state    <= FIN;
            end else begin
              evt_time <= best[32] ? TIME_MAX : best[31:0];
              state    <= CREDIT;
            end
          end else begin
            if (running_flags[ii]) begin
              if (!have || finish < best) begin
                best <= finish;
              end
              have <= 1'b1;
            end
            i <= i + 1'b1;
          end
        end
        CREDIT: begin
          if (i == loaded_count) begin
            current_time <= evt_time;
            state        <= ADMIT;
          end else begin
            if (running_flags[ii]) begin
              ticks_served[ii] <= ticks_served[ii]
                                  + ((delta < {16'b0, rem}) ? delta[15:0] : rem);
            end
            i <= i + 1'b1;
          end
        end
        ADMIT: begin
          if (admit_pointer < loaded_count && task_arrival[ap] <= current_time) begin
            admitted_flags[ap] <= 1'b1;
            admit_pointer      <= admit_pointer + 1'b1;
          end else begin
            taken <= '0;
            run   <= '0;
            used  <= '0;
            found <= 1'b0;
            i     <= '0;
            state <= PACK;
          end
        end
        PACK: begin
          // Each full pass picks the best remaining task; first fit decides
          // whether it runs.
          if (i == loaded_count) begin
            i     <= '0;
            found <= 1'b0;
            if (!found) begin
              state <= EMIT;
            end else begin
              taken[pick] <= 1'b1;
              if (used_sum <= {1'b0, capacity}) begin
                used      <= used_sum[15:0];
                run[pick] <= 1'b1;
              end
            end
          end else begin
            // Scan order is increasing, so a tie keeps the earlier pick.
            if (eligible && (!found || prod_a > prod_b)) begin
              found       <= 1'b1;
              pick        <= ii;
              pick_weight <= task_weight[ii];
              pick_length <= task_length[ii];
              pick_need   <= task_need[ii];
            end
            i <= i + 1'b1;
          end
        end
        EMIT: begin
          if (i == loaded_count) begin
            running_flags <= run;
            fin_kind      <= KIND_ADVANCE;
            fin_done      <= (admit_pointer >= loaded_count) && (run == '0);
            state         <= FIN;
          end else if (closes) begin
            if (!out_full) begin
              i <= i + 1'b1;
            end
          end else begin
            if (!running_flags[ii] && run[ii]) begin
              open_range_start[ii] <= current_time;
            end
            i <= i + 1'b1;
          end
        end
        FIN: begin
          if (!out_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/weighted_ratio_task_scheduler.sv =====
// A load is written into the task table as it is popped; a rejected load is
// answered from FIN. An advance walks the table through EVT, CREDIT, ADMIT,
// PACK, EMIT and FIN, holding in EMIT or FIN while the result queue is full.
// Throughput is one request at a time, set by the table walk in the back end.
// Reset (synchronous, rst high): queues empty, time zero, no task loaded.
// ----------------------------------------------------------------------------
// weighted_ratio_task_scheduler
// Preemptive weighted-ratio scheduler under a resource capacity, with a
// request queue in front, a sequencing back end and a result queue.
// ----------------------------------------------------------------------------
module weighted_ratio_task_scheduler
  import wrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] capacity;
  req_t        q_item;
  logic        q_empty;
  logic        q_pop;
  rsp_t        r_item;
  logic        r_push;
  logic        r_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'b0, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      capacity <= pwdata[15:0];
    end
  end

  wrts_fifo #(.WIDTH($bits(req_t)), .DEPTH(2)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (req),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  wrts_core #(.MAX_TASKS(MAX_TASKS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .in_item  (q_item),
    .in_empty (q_empty),
    .in_pop   (q_pop),
    .out_item (r_item),
    .out_push (r_push),
    .out_full (r_full)
  );

  wrts_fifo #(.WIDTH($bits(rsp_t)), .DEPTH(4)) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_item),
    .full  (r_full),
    .pop   (pop),
    .rdata (rsp),
    .empty (empty)
  );

  // A waiting result is never withdrawn before it is taken.
  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp))
    else $error("result changed or vanished before pop");

  // Only closed ranges may be followed by more results of the same request.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    !empty && !rsp.last |-> rsp.kind == KIND_RANGE)
    else $error("non-final result is not a range");

  // Range results never claim that the schedule is finished.
  a_range_done: assert property (@(posedge clk) disable iff (rst)
    !empty && rsp.kind == KIND_RANGE |-> !rsp.all_done && !rsp.last)
    else $error("range result flagged as done or last");

endmodule
